// File: sv/fbfl_pkg.sv
// Shared constants and types for the fixed-block free-list pool.
package fbfl_pkg;

    localparam int MaxSlots = 256;
    localparam int PtrBytes = 4;

    localparam int SlotW   = $clog2(MaxSlots);
    localparam int LinkW   = SlotW + 1;
    localparam int BaseW   = 32;
    localparam int BytesW  = 21;
    localparam int ItemW   = 16;
    localparam int StrideW = ItemW + 1;
    localparam int ProdW   = SlotW + StrideW;
    localparam int AddrW   = 32;
    localparam int CfgW    = 32;
    localparam int CfgIdxW = 2;

    localparam logic [LinkW-1:0] LinkNone = LinkW'(MaxSlots);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_INVALID = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BASE  = 2'd0,
        CFG_BYTES = 2'd1,
        CFG_ITEM  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_INIT
    } state_t;

    typedef struct packed {
        logic             en;
        logic [SlotW-1:0] addr;
        logic [LinkW-1:0] data;
    } link_wr_t;

endpackage

// File: sv/fixed_block_free_list_pool.sv
// Fixed-size block pool: LIFO free list of slot indices held in a link memory.
// Timing: free, and any operation that fails, registers its result in the
// cycle after the transfer. A successful allocate passes through S_ALLOC,
// since the head's link is read from the registered-read link memory before
// the head can move. Initialize walks the single link memory write port from
// slot 0 upwards in S_INIT over up to 256 slots. There is no clearing pass
// after reset. A new transfer is taken once the current operation is finished
// and the output register is empty or its result is transferred in that cycle.
module fixed_block_free_list_pool (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [fbfl_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [fbfl_pkg::CfgW-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic [fbfl_pkg::SlotW-1:0]    slot_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [fbfl_pkg::SlotW-1:0]    granted_slot,
    output logic [fbfl_pkg::AddrW-1:0]    granted_address,
    output logic                          pool_ready
);

    import fbfl_pkg::*;

    logic [BaseW-1:0]   buffer_base_reg;
    logic [BytesW-1:0]  buffer_bytes_reg;
    logic [ItemW-1:0]   item_bytes_reg;

    state_t             state_reg, state_next;
    logic [LinkW-1:0]   head_reg, head_next;
    logic [BaseW-1:0]   held_base_reg, held_base_next;
    logic [StrideW-1:0] held_stride_reg, held_stride_next;
    logic [SlotW-1:0]   walk_k_reg, walk_k_next;
    logic [BytesW-1:0]  walk_acc_reg, walk_acc_next;
    logic [ProdW-1:0]   prod_reg, prod_next;
    logic [SlotW-1:0]   grant_reg, grant_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [SlotW-1:0]   granted_slot_reg, granted_slot_next;
    logic [AddrW-1:0]   granted_address_reg, granted_address_next;
    logic               pool_ready_reg, pool_ready_next;

    logic               in_xfer;
    logic               out_xfer;
    logic               out_free;
    logic [StrideW-1:0] stride_calc;
    logic [BytesW:0]    walk_sum;
    logic               walk_last;
    logic [LinkW-1:0]   rd_link;
    link_wr_t           link_wr;

    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign in_xfer  = in_valid && !in_stall;

    assign stride_calc = StrideW'(((StrideW'(item_bytes_reg) + StrideW'(PtrBytes - 1))
                         / PtrBytes) * PtrBytes);

    assign walk_sum  = {1'b0, walk_acc_reg} + (BytesW + 1)'(held_stride_reg);
    assign walk_last = (walk_k_reg == SlotW'(MaxSlots - 1))
                       || (walk_sum > {1'b0, buffer_bytes_reg});

    fbfl_ram #(
        .Depth (MaxSlots),
        .Width (LinkW)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr.en),
        .wr_addr (link_wr.addr),
        .wr_data (link_wr.data),
        .rd_addr (head_reg[SlotW-1:0]),
        .rd_data (rd_link)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_base_reg  <= '0;
            buffer_bytes_reg <= '0;
            item_bytes_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BASE:  buffer_base_reg  <= cfg_data[BaseW-1:0];
                CFG_BYTES: buffer_bytes_reg <= cfg_data[BytesW-1:0];
                CFG_ITEM:  item_bytes_reg   <= cfg_data[ItemW-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= LinkNone;
            held_base_reg   <= '0;
            held_stride_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            held_base_reg   <= held_base_next;
            held_stride_reg <= held_stride_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_k_reg          <= walk_k_next;
        walk_acc_reg        <= walk_acc_next;
        prod_reg            <= prod_next;
        grant_reg           <= grant_next;
        status_reg          <= status_next;
        granted_slot_reg    <= granted_slot_next;
        granted_address_reg <= granted_address_next;
        pool_ready_reg      <= pool_ready_next;
    end

    always_comb
    begin
        state_next           = state_reg;
        head_next            = head_reg;
        held_base_next       = held_base_reg;
        held_stride_next     = held_stride_reg;
        walk_k_next          = walk_k_reg;
        walk_acc_next        = walk_acc_reg;
        prod_next            = prod_reg;
        grant_next           = grant_reg;
        out_valid_next       = out_xfer ? 1'b0 : out_valid_reg;
        status_next          = status_reg;
        granted_slot_next    = granted_slot_reg;
        granted_address_next = granted_address_reg;
        pool_ready_next      = pool_ready_reg;
        link_wr              = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    status_next          = ST_OK;
                    granted_slot_next    = '0;
                    granted_address_next = '0;
                    pool_ready_next      = !head_reg[SlotW];
                    out_valid_next       = 1'b1;
                    case (op_t'(operation))
                        OP_ALLOC:
                        begin
                            if (head_reg[SlotW])
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                grant_next     = head_reg[SlotW-1:0];
                                prod_next      = ProdW'(head_reg[SlotW-1:0])
                                                 * ProdW'(held_stride_reg);
                                state_next     = S_ALLOC;
                            end
                        end
                        OP_FREE:
                        begin
                            link_wr.en      = 1'b1;
                            link_wr.addr    = slot_index;
                            link_wr.data    = head_reg;
                            head_next       = {1'b0, slot_index};
                            pool_ready_next = 1'b1;
                        end
                        OP_INIT:
                        begin
                            if (!head_reg[SlotW])
                            begin
                                status_next = ST_BUSY;
                            end
                            else if (buffer_base_reg == '0 || buffer_bytes_reg == '0
                                     || item_bytes_reg == '0
                                     || BytesW'(stride_calc) > buffer_bytes_reg)
                            begin
                                status_next = ST_INVALID;
                            end
                            else
                            begin
                                out_valid_next   = 1'b0;
                                held_base_next   = buffer_base_reg;
                                held_stride_next = stride_calc;
                                walk_k_next      = '0;
                                walk_acc_next    = BytesW'(stride_calc);
                                state_next       = S_INIT;
                            end
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                head_next            = rd_link;
                status_next          = ST_OK;
                granted_slot_next    = grant_reg;
                granted_address_next = held_base_reg + AddrW'(prod_reg);
                pool_ready_next      = (rd_link != LinkNone);
                out_valid_next       = 1'b1;
                state_next           = S_IDLE;
            end
            S_INIT:
            begin
                link_wr.en   = 1'b1;
                link_wr.addr = walk_k_reg;
                link_wr.data = (walk_k_reg == '0) ? LinkNone
                               : LinkW'(walk_k_reg - SlotW'(1));
                if (walk_last)
                begin
                    head_next            = {1'b0, walk_k_reg};
                    status_next          = ST_OK;
                    granted_slot_next    = '0;
                    granted_address_next = '0;
                    pool_ready_next      = 1'b1;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    walk_k_next   = walk_k_reg + SlotW'(1);
                    walk_acc_next = walk_sum[BytesW-1:0];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign granted_slot    = granted_slot_reg;
    assign granted_address = granted_address_reg;
    assign pool_ready      = pool_ready_reg;

    // successful allocate: result is registered from S_ALLOC, the state after the transfer
    a_alloc_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && operation == OP_ALLOC && !head_reg[SlotW]) |=> ##1 out_valid_reg)
        else $error("allocate result missing");

    a_empty_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_EMPTY)
        |-> (!pool_ready_reg && granted_slot_reg == '0 && granted_address_reg == '0))
        else $error("empty result inconsistent");

    a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_BUSY) |-> pool_ready_reg)
        else $error("busy result with empty list");

endmodule

// File: sv/fbfl_ram.sv
// Single-port-write, registered-read link memory.
module fbfl_ram #(
    parameter int Depth = 256,
    parameter int Width = 9
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
